### src/pbr_pkg.sv
// pbr_pkg: shared types and default constants of the polynomial bisection refiner
// used by pbr_poly_eval, the top level and the checker; no dependencies
package pbr_pkg;

   localparam int MAX_TERMS_DEF    = 16;
   localparam int MAX_POWER_DEF    = 15;
   localparam int BISECT_STEPS_DEF = 16;

   localparam logic OP_WRITE_TERM = 1'b0;
   localparam logic OP_REFINE     = 1'b1;

   // csr register index (byte address / 4)
   localparam logic REG_TERMS_IN_USE = 1'b0;

   typedef struct packed {
      logic               opcode;
      logic [3:0]         term_slot;
      logic signed [31:0] term_coefficient;
      logic [3:0]         term_power;
      logic signed [31:0] left_end;
      logic signed [31:0] right_end;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] root_estimate;
      logic               exact_zero;
      logic               saturated;
   } rsp_payload_type;

   // evaluation request / reply between top level and evaluator
   typedef struct packed {
      logic               start;
      logic signed [31:0] x;
   } eval_req_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] value;
      logic               sat;
   } eval_rsp_type;

endpackage

### src/pbr_ram.sv
// pbr_ram: generic single write port, single read port RAM with registered read
// no dependencies
module pbr_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### src/pbr_poly_eval.sv
// pbr_poly_eval: sequential polynomial evaluator with one shared 32x32 multiplier
// depends on pbr_pkg; reads the term table through its rd_addr / rd_data port
module pbr_poly_eval #(
   parameter int MAX_TERMS = pbr_pkg::MAX_TERMS_DEF,
   parameter int MAX_POWER = pbr_pkg::MAX_POWER_DEF,
   parameter int AW        = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
   parameter int CW        = $clog2(MAX_TERMS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pbr_pkg::eval_req_type eval_req,
   input  logic [CW-1:0]         num_terms,
   output pbr_pkg::eval_rsp_type eval_rsp,
   output logic [AW-1:0]         rd_addr,
   input  logic [35:0]           rd_data
);
   localparam logic [2:0] E_IDLE = 3'd0;
   localparam logic [2:0] E_RD   = 3'd1;
   localparam logic [2:0] E_LD   = 3'd2;
   localparam logic [2:0] E_MH   = 3'd3;
   localparam logic [2:0] E_ML   = 3'd4;
   localparam logic [2:0] E_CMB  = 3'd5;
   localparam logic [2:0] E_ADD  = 3'd6;

   localparam logic [63:0] CAP63   = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
   localparam logic [63:0] LIM47   = 64'h0000_8000_0000_0000;
   localparam logic [63:0] LIM31   = 64'h0000_0000_8000_0000;

   logic [2:0]         state_ff, state_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [31:0]        ax_ff, ax_in;
   logic               xneg_ff, xneg_in;
   logic [31:0]        ac_ff, ac_in;
   logic               cneg_ff, cneg_in;
   logic [3:0]         deg_ff, deg_in;
   logic [3:0]         k_ff, k_in;
   logic               mode_int_ff, mode_int_in;
   logic [63:0]        p_ff, p_in;
   logic [63:0]        prod_ff, prod_in;
   logic [63:0]        hi_ff, hi_in;
   logic signed [63:0] acc_ff, acc_in;
   logic               sat_ff, sat_in;
   logic               done_ff, done_in;

   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_p;
   logic [64:0]        comb_s;
   logic               comb_cap;
   logic [63:0]        comb_r;
   logic signed [31:0] coef;
   logic [3:0]         pw;
   logic [3:0]         deg_clamped;
   logic               term_neg;
   logic signed [63:0] term_t;
   logic               term_sat;
   logic signed [64:0] add_s;

   assign coef = rd_data[31:0];
   assign pw   = rd_data[35:32];
   assign deg_clamped = ({28'd0, pw} > MAX_POWER) ? 4'(MAX_POWER) : pw;

   // the shared multiplier
   assign mul_a = (state_ff == E_MH) ? p_ff[63:32] : p_ff[31:0];
   assign mul_b = mode_int_ff ? ac_ff : ax_ff;
   assign mul_p = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      if (mode_int_ff) begin
         comb_cap = hi_ff > LIM31;
         comb_s   = {1'b0, hi_ff[31:0], 32'd0} + {1'b0, prod_ff};
      end else begin
         comb_cap = hi_ff > LIM47;
         comb_s   = {1'b0, hi_ff[47:0], 16'd0} + {17'd0, prod_ff[63:16]};
      end
      if (comb_s > {1'b0, CAP63}) begin
         comb_cap = 1'b1;
      end
      comb_r = comb_cap ? CAP63 : comb_s[63:0];
   end

   always_comb begin
      term_neg = cneg_ff ^ (xneg_ff & deg_ff[0]);
      term_sat = 1'b0;
      if (term_neg) begin
         term_t = (p_ff == CAP63) ? $signed(CAP63) : -$signed(p_ff);
      end else if (p_ff == CAP63) begin
         term_t   = $signed(~CAP63);
         term_sat = 1'b1;
      end else begin
         term_t = $signed(p_ff);
      end
      add_s = {acc_ff[63], acc_ff} + {term_t[63], term_t};
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      ax_in       = ax_ff;
      xneg_in     = xneg_ff;
      ac_in       = ac_ff;
      cneg_in     = cneg_ff;
      deg_in      = deg_ff;
      k_in        = k_ff;
      mode_int_in = mode_int_ff;
      p_in        = p_ff;
      prod_in     = prod_ff;
      hi_in       = hi_ff;
      acc_in      = acc_ff;
      sat_in      = sat_ff;
      done_in     = 1'b0;
      unique case (state_ff)
         E_IDLE: begin
            if (eval_req.start) begin
               xneg_in = eval_req.x[31];
               ax_in   = eval_req.x[31] ? (32'd0 - eval_req.x) : eval_req.x;
               idx_in  = '0;
               acc_in  = '0;
               sat_in  = 1'b0;
               if (num_terms == '0) begin
                  done_in = 1'b1;
               end else begin
                  state_in = E_RD;
               end
            end
         end
         E_RD: begin
            state_in = E_LD;
         end
         E_LD: begin
            cneg_in     = coef[31];
            ac_in       = coef[31] ? (32'd0 - coef) : coef;
            deg_in      = deg_clamped;
            k_in        = '0;
            p_in        = ONE_Q32;
            mode_int_in = (deg_clamped == 4'd0);
            state_in    = E_MH;
         end
         E_MH: begin
            prod_in  = mul_p;
            state_in = E_ML;
         end
         E_ML: begin
            hi_in    = prod_ff;
            prod_in  = mul_p;
            state_in = E_CMB;
         end
         E_CMB: begin
            p_in = comb_r;
            if (comb_cap) begin
               sat_in = 1'b1;
            end
            if (mode_int_ff) begin
               state_in = E_ADD;
            end else begin
               k_in = k_ff + 4'd1;
               if (k_ff + 4'd1 == deg_ff) begin
                  mode_int_in = 1'b1;
               end
               state_in = E_MH;
            end
         end
         E_ADD: begin
            if (term_sat) begin
               sat_in = 1'b1;
            end
            if (add_s[64] != add_s[63]) begin
               sat_in = 1'b1;
               acc_in = add_s[64] ? $signed(CAP63) : $signed(~CAP63);
            end else begin
               acc_in = add_s[63:0];
            end
            if (idx_ff + CW'(1) == num_terms) begin
               done_in  = 1'b1;
               state_in = E_IDLE;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = E_RD;
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      idx_ff      <= idx_in;
      ax_ff       <= ax_in;
      xneg_ff     <= xneg_in;
      ac_ff       <= ac_in;
      cneg_ff     <= cneg_in;
      deg_ff      <= deg_in;
      k_ff        <= k_in;
      mode_int_ff <= mode_int_in;
      p_ff        <= p_in;
      prod_ff     <= prod_in;
      hi_ff       <= hi_in;
      acc_ff      <= acc_in;
      sat_ff      <= sat_in;
   end

   assign rd_addr        = idx_ff[AW-1:0];
   assign eval_rsp.done  = done_ff;
   assign eval_rsp.value = acc_ff;
   assign eval_rsp.sat   = sat_ff;
endmodule

### src/polynomial_bisection_refiner_unit.sv
// polynomial_bisection_refiner_unit: top level, command channel, csr port, bisection sequencer
// depends on pbr_pkg, pbr_ram and pbr_poly_eval
//
// A term write (opcode 0) is taken while busy stays low. A refine (opcode 1) raises
// busy and runs BISECT_STEPS steps; each step forms mid, evaluates f(mid) and then f(lo),
// where f sums the terms in use; f(lo) is skipped when f(mid) is exactly zero. The
// evaluator does each power multiply on one 32x32 multiplier in states E_MH, E_ML and
// E_CMB, and reads the terms one at a time from the table.
// The result appears on rsp_payload for exactly one cycle with rsp_valid high, in the cycle
// busy drops; the receiver cannot stall it and must take it then. The term table holds
// garbage until written; refine only with all slots below terms_in_use written.
module polynomial_bisection_refiner_unit #(
   parameter int MAX_TERMS    = pbr_pkg::MAX_TERMS_DEF,
   parameter int MAX_POWER    = pbr_pkg::MAX_POWER_DEF,
   parameter int BISECT_STEPS = pbr_pkg::BISECT_STEPS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  pbr_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   output pbr_pkg::rsp_payload_type rsp_payload,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [2:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CW = $clog2(MAX_TERMS + 1);
   localparam int SW = $clog2(BISECT_STEPS + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MID  = 2'd1;
   localparam logic [1:0] S_EVM  = 2'd2;
   localparam logic [1:0] S_EVL  = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [4:0]               terms_ff;
   logic signed [31:0]       lo_ff, lo_in;
   logic signed [31:0]       hi_ff, hi_in;
   logic signed [31:0]       mid_ff, mid_in;
   logic signed [63:0]       fm_ff, fm_in;
   logic [SW-1:0]            step_ff, step_in;
   logic                     exact_ff, exact_in;
   logic                     sat_ff, sat_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   pbr_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic                     accept;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [AW-1:0]            rd_addr;
   logic [35:0]              rd_data;
   logic [CW-1:0]            num_terms;
   logic signed [32:0]       mid_sum;
   logic                     step_last;
   logic                     step_done;
   pbr_pkg::eval_req_type    eval_req;
   pbr_pkg::eval_rsp_type    eval_rsp;

   assign accept  = start && !busy;
   assign wr_en   = accept && (req_payload.opcode == pbr_pkg::OP_WRITE_TERM)
                    && ({28'd0, req_payload.term_slot} < MAX_TERMS);
   assign wr_addr = AW'(req_payload.term_slot);

   assign num_terms = ({27'd0, terms_ff} > MAX_TERMS) ? CW'(MAX_TERMS) : CW'(terms_ff);
   assign mid_sum   = {lo_ff[31], lo_ff} + {hi_ff[31], hi_ff};
   assign step_last = (step_ff + SW'(1) == SW'(BISECT_STEPS));

   pbr_ram #(
      .WIDTH (36),
      .DEPTH (MAX_TERMS),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_payload.term_power, req_payload.term_coefficient}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pbr_poly_eval #(
      .MAX_TERMS (MAX_TERMS),
      .MAX_POWER (MAX_POWER),
      .AW        (AW),
      .CW        (CW)
   ) u_eval (
      .clock     (clock),
      .reset     (reset),
      .eval_req  (eval_req),
      .num_terms (num_terms),
      .eval_rsp  (eval_rsp),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      fm_in        = fm_ff;
      step_in      = step_ff;
      exact_in     = exact_ff;
      sat_in       = sat_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      eval_req     = '0;
      step_done    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_payload.opcode == pbr_pkg::OP_REFINE) begin
               lo_in    = req_payload.left_end;
               hi_in    = req_payload.right_end;
               step_in  = '0;
               exact_in = 1'b0;
               sat_in   = 1'b0;
               state_in = S_MID;
            end
         end
         S_MID: begin
            mid_in         = mid_sum[32:1];
            eval_req.start = 1'b1;
            eval_req.x     = mid_sum[32:1];
            state_in       = S_EVM;
         end
         S_EVM: begin
            if (eval_rsp.done) begin
               sat_in = sat_ff | eval_rsp.sat;
               fm_in  = eval_rsp.value;
               if (eval_rsp.value == 64'sd0) begin
                  lo_in     = mid_ff;
                  hi_in     = mid_ff;
                  exact_in  = 1'b1;
                  step_done = 1'b1;
               end else begin
                  eval_req.start = 1'b1;
                  eval_req.x     = lo_ff;
                  state_in       = S_EVL;
               end
            end
         end
         S_EVL: begin
            if (eval_rsp.done) begin
               sat_in = sat_ff | eval_rsp.sat;
               // same strict sign moves lo, otherwise (f(lo) zero too) hi moves
               if ((eval_rsp.value > 0 && fm_ff > 0) || (eval_rsp.value < 0 && fm_ff < 0)) begin
                  lo_in = mid_ff;
               end else begin
                  hi_in = mid_ff;
               end
               step_done = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (step_done) begin
         if (step_last) begin
            rsp_valid_in          = 1'b1;
            rsp_in.root_estimate  = lo_in;
            rsp_in.exact_zero     = exact_in;
            rsp_in.saturated      = sat_in;
            state_in              = S_IDLE;
         end else begin
            step_in  = step_ff + SW'(1);
            state_in = S_MID;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         terms_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (psel && penable && pwrite && pready && paddr[2] == pbr_pkg::REG_TERMS_IN_USE) begin
            terms_ff <= pwdata[4:0];
         end
      end
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      fm_ff    <= fm_in;
      step_ff  <= step_in;
      exact_ff <= exact_in;
      sat_ff   <= sat_in;
      rsp_ff   <= rsp_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign pready      = 1'b1;
   assign prdata      = (paddr[2] == pbr_pkg::REG_TERMS_IN_USE) ? {27'd0, terms_ff} : 32'd0;
endmodule

### src/pbr_checker.sv
// pbr_checker: port-level assertions for the bisection refiner, bound to the top level
// depends on pbr_pkg and polynomial_bisection_refiner_unit
module pbr_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input pbr_pkg::req_payload_type req_payload,
   input logic                     rsp_valid
);
   // a refine beat always raises busy
   a_refine_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_payload.opcode == pbr_pkg::OP_REFINE |=> busy)
      else $error("refine beat did not raise busy");

   // a term write finishes in its own cycle and gives no result
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_payload.opcode == pbr_pkg::OP_WRITE_TERM |=> !busy && !rsp_valid)
      else $error("term write raised busy or a result");

   // a result beat comes exactly as busy drops
   a_rsp_on_fall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("result beat outside the end of a refine");

   // results never come in consecutive cycles
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");
endmodule

bind polynomial_bisection_refiner_unit pbr_checker u_pbr_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid)
);

### sim/tb_polynomial_bisection_refiner_unit.sv
// tb_polynomial_bisection_refiner_unit: self-checking bench for the bisection refiner,
// with an in-bench predictor of term writes and Q16.16 refines and an apb-style csr master
// depends on pbr_pkg and polynomial_bisection_refiner_unit
`timescale 1ns / 100ps

module tb_polynomial_bisection_refiner_unit;

   localparam longint INT64_MAX = 64'sh7fff_ffff_ffff_ffff;
   localparam longint INT64_MIN = -64'sh7fff_ffff_ffff_ffff - 1;
   localparam logic [63:0] CAP63 = 64'h8000_0000_0000_0000;
   localparam logic [63:0] LO32 = 64'h0000_0000_ffff_ffff;
   localparam int STALL_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   pbr_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   pbr_pkg::rsp_payload_type rsp_payload;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   // predictor state
   logic signed [31:0] coef_mirror [16];
   logic [3:0] power_mirror [16];
   int unsigned active_terms = 0;
   bit eval_clipped;

   pbr_pkg::req_payload_type pending_cmds [$];
   pbr_pkg::rsp_payload_type expected_roots [$];
   int fail_count = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int gap_left = 0;

   polynomial_bisection_refiner_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #4 clock = ~clock;

   // |p| in Q32.32 times |x| in Q16.16, truncated and capped
   function automatic logic [63:0] mul_by_x(logic [63:0] p, logic [63:0] ax);
      logic [63:0] hi_prod;
      logic [63:0] sum;
      hi_prod = (p >> 32) * ax;
      if (hi_prod > (64'd1 << 47)) begin
         eval_clipped = 1'b1;
         return CAP63;
      end
      sum = (hi_prod << 16) + (((p & LO32) * ax) >> 16);
      if (sum > CAP63) begin
         eval_clipped = 1'b1;
         return CAP63;
      end
      return sum;
   endfunction

   function automatic logic [63:0] mul_by_coef(logic [63:0] p, logic [63:0] ac);
      logic [63:0] hi_prod;
      logic [63:0] sum;
      hi_prod = (p >> 32) * ac;
      if (hi_prod > (64'd1 << 31)) begin
         eval_clipped = 1'b1;
         return CAP63;
      end
      sum = (hi_prod << 32) + (p & LO32) * ac;
      if (sum > CAP63) begin
         eval_clipped = 1'b1;
         return CAP63;
      end
      return sum;
   endfunction

   function automatic longint poly_value(longint x);
      longint acc;
      longint term;
      longint c;
      logic [63:0] ax;
      logic [63:0] pw;
      logic [63:0] mag;
      bit neg;
      int n;
      acc = 0;
      n = (active_terms > 16) ? 16 : active_terms;
      ax = (x < 0) ? -x : x;
      for (int i = 0; i < n; i++) begin
         c = coef_mirror[i];
         pw = 64'd1 << 32;
         for (int k = 0; k < power_mirror[i]; k++) pw = mul_by_x(pw, ax);
         mag = mul_by_coef(pw, (c < 0) ? -c : c);
         neg = (c < 0) != (x < 0 && power_mirror[i][0]);
         if (neg) begin
            term = (mag == CAP63) ? INT64_MIN : -longint'(mag);
         end else if (mag == CAP63) begin
            eval_clipped = 1'b1;
            term = INT64_MAX;
         end else begin
            term = longint'(mag);
         end
         if (term > 0 && acc > INT64_MAX - term) begin
            eval_clipped = 1'b1;
            acc = INT64_MAX;
         end else if (term < 0 && acc < INT64_MIN - term) begin
            eval_clipped = 1'b1;
            acc = INT64_MIN;
         end else begin
            acc = acc + term;
         end
      end
      return acc;
   endfunction

   function automatic pbr_pkg::rsp_payload_type refine_interval(logic signed [31:0] left,
                                                                logic signed [31:0] right);
      pbr_pkg::rsp_payload_type r;
      longint lo;
      longint hi;
      longint mid;
      longint fm;
      longint fl;
      bit hit_zero;
      lo = left;
      hi = right;
      hit_zero = 1'b0;
      eval_clipped = 1'b0;
      for (int s = 0; s < pbr_pkg::BISECT_STEPS_DEF; s++) begin
         mid = (lo + hi) >>> 1;
         fm = poly_value(mid);
         if (fm == 0) begin
            lo = mid;
            hi = mid;
            hit_zero = 1'b1;
         end else begin
            fl = poly_value(lo);
            if ((fl > 0 && fm > 0) || (fl < 0 && fm < 0)) lo = mid;
            else hi = mid;
         end
      end
      r.root_estimate = lo[31:0];
      r.exact_zero = hit_zero;
      r.saturated = eval_clipped;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // driver: one beat per accepted command, bursts separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            idle_cycles = 0;
            if (req_payload.opcode == pbr_pkg::OP_REFINE) begin
               expected_roots.push_back(refine_interval(req_payload.left_end,
                                                        req_payload.right_end));
            end else begin
               coef_mirror[req_payload.term_slot] = req_payload.term_coefficient;
               power_mirror[req_payload.term_slot] = req_payload.term_power;
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            start <= 1'b1;
            req_payload <= pending_cmds.pop_front();
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 8);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: results cannot be held off, so every strobe is a beat
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         idle_cycles = 0;
         if (expected_roots.size() == 0) begin
            report_mismatch("unexpected result", rsp_payload.root_estimate, 0);
         end else begin
            pbr_pkg::rsp_payload_type want;
            want = expected_roots.pop_front();
            if (rsp_payload.root_estimate !== want.root_estimate)
               report_mismatch("root_estimate", rsp_payload.root_estimate, want.root_estimate);
            if (rsp_payload.exact_zero !== want.exact_zero)
               report_mismatch("exact_zero", rsp_payload.exact_zero, want.exact_zero);
            if (rsp_payload.saturated !== want.saturated)
               report_mismatch("saturated", rsp_payload.saturated, want.saturated);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL polynomial_bisection_refiner_unit");
            $finish;
         end
      end
   end

   function automatic pbr_pkg::req_payload_type term_cmd(int slot, int c, int p);
      pbr_pkg::req_payload_type q;
      q = '0;
      q.opcode = pbr_pkg::OP_WRITE_TERM;
      q.term_slot = 4'(slot);
      q.term_coefficient = 32'(c);
      q.term_power = 4'(p);
      return q;
   endfunction

   function automatic pbr_pkg::req_payload_type refine_cmd(int left, int right);
      pbr_pkg::req_payload_type q;
      q = '0;
      q.opcode = pbr_pkg::OP_REFINE;
      q.left_end = left;
      q.right_end = right;
      return q;
   endfunction

   task automatic wait_quiet();
      do @(posedge clock);
      while (pending_cmds.size() > 0 || expected_roots.size() > 0 || start || busy);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_terms_in_use(int n);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {pbr_pkg::REG_TERMS_IN_USE, 2'b00};
      pwdata <= n;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      active_terms = n;
      idle_cycles = 0;
   endtask

   function automatic pbr_pkg::req_payload_type random_cmd();
      pbr_pkg::req_payload_type q;
      int span;
      q = '0;
      q.term_slot = 4'($urandom_range(0, 15));
      q.term_power = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
         0: q.term_coefficient = $urandom;
         1: q.term_coefficient = $urandom_range(0, 2000) - 1000;
         default: q.term_coefficient = $urandom_range(0, 16) - 8;
      endcase
      if ($urandom_range(0, 2) == 0) begin
         q.opcode = pbr_pkg::OP_WRITE_TERM;
         q.left_end = $urandom;
         q.right_end = $urandom;
      end else begin
         q.opcode = pbr_pkg::OP_REFINE;
         if ($urandom_range(0, 4) == 0) begin
            q.left_end = $urandom;
            q.right_end = $urandom;
         end else begin
            // mostly small intervals around the origin, a few reversed
            span = $urandom_range(1, 8) << 16;
            q.left_end = -int'($urandom_range(0, span));
            q.right_end = $urandom_range(0, span);
            if ($urandom_range(0, 7) == 0) begin
               q.left_end = q.right_end;
               q.right_end = -int'($urandom_range(0, span));
            end
         end
      end
      return q;
   endfunction

   initial begin
      int phase_terms [8] = '{1, 3, 16, 4, 0, 2, 4, 1};
      for (int i = 0; i < 16; i++) begin
         coef_mirror[i] = '0;
         power_mirror[i] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // no terms in use: f is identically zero, every midpoint is a root
      pending_cmds.push_back(refine_cmd(32'sh8000_0000, 32'sh7fff_ffff));
      pending_cmds.push_back(refine_cmd(5 << 16, -(3 << 16)));
      // x^2 - 2, then extreme coefficients at degree 15 in slots 2 and 3, small ones in the rest
      pending_cmds.push_back(term_cmd(0, -2, 0));
      pending_cmds.push_back(term_cmd(1, 1, 2));
      pending_cmds.push_back(term_cmd(2, 32'h7fff_ffff, 15));
      pending_cmds.push_back(term_cmd(3, 32'sh8000_0000, 15));
      for (int i = 4; i < 16; i++) pending_cmds.push_back(term_cmd(i, i - 10, i));
      wait_quiet();

      write_terms_in_use(2);
      pending_cmds.push_back(refine_cmd(0, 2 << 16));
      pending_cmds.push_back(refine_cmd(-(2 << 16), 0));
      pending_cmds.push_back(refine_cmd(0, 3 << 16));
      wait_quiet();

      // huge coefficients at large x drive the accumulator into saturation
      write_terms_in_use(4);
      pending_cmds.push_back(refine_cmd(32'sh8000_0000, 32'sh7fff_ffff));
      pending_cmds.push_back(refine_cmd(1 << 16, 100 << 16));
      wait_quiet();

      foreach (phase_terms[p]) begin
         write_terms_in_use(phase_terms[p]);
         if (phase_terms[p] == 16) begin
            for (int i = 0; i < 4; i++) begin
               pbr_pkg::req_payload_type q;
               q = random_cmd();
               if (q.opcode == pbr_pkg::OP_WRITE_TERM) q.term_power = 4'($urandom_range(0, 3));
               pending_cmds.push_back(q);
            end
         end else begin
            for (int i = 0; i < 38; i++) pending_cmds.push_back(random_cmd());
         end
         wait_quiet();
      end

      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS polynomial_bisection_refiner_unit");
      end else begin
         $display("FAIL polynomial_bisection_refiner_unit");
      end
      $finish;
   end

endmodule
